/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the RTL files.
// Each macro takes a label, a clock, an active-low reset, a condition and a consequence.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define QADS_ASSERT_IMP(label, ck, rst_n, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define QADS_ASSERT_NXT(label, ck, rst_n, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define QADS_ASSERT_IMP(label, ck, rst_n, ante, cons)
`define QADS_ASSERT_NXT(label, ck, rst_n, ante, cons)
`endif
`endif

/* hw/rtl/qads_pkg.sv */
package qads_pkg;

	// Sizes of the splitter.
	localparam int MAX_DELIM   = 4;
	localparam int POS_BITS    = 16;
	localparam int CHAR_W      = 16;
	localparam int DCHARS      = 4;
	localparam int DELIM_REG_W = DCHARS * CHAR_W;
	localparam int LEN_W       = 3;
	localparam int FILL_W      = $clog2(MAX_DELIM + 1);
	localparam int POSX_W      = POS_BITS + FILL_W;
	localparam int OUT_W       = 16;
	localparam int FLAG_W      = 5;
	localparam int REG_IDX_W   = 2;
	localparam int PUSH_W      = 2;
	localparam int FIFO_DEPTH  = 4;
	localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

	localparam logic [POS_BITS-1:0] POS_MAX = '1;

	// Register indexes on the configuration port.
	localparam logic [REG_IDX_W-1:0] REG_DELIM_CHARS  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_DELIM_LENGTH = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_TRIM_ENABLE  = 2'd2;

	// Register values after reset: a single comma, no trimming.
	localparam logic [DELIM_REG_W-1:0] RST_DELIM_CHARS  = 64'd44;
	localparam logic [LEN_W-1:0]       RST_DELIM_LENGTH = 3'd1;

	// Characters with a meaning of their own.
	localparam logic [CHAR_W-1:0] CH_SQUOTE  = 16'h0027;
	localparam logic [CHAR_W-1:0] CH_DQUOTE  = 16'h0022;
	localparam logic [CHAR_W-1:0] CH_LPAREN  = 16'h0028;
	localparam logic [CHAR_W-1:0] CH_RPAREN  = 16'h0029;
	localparam logic [CHAR_W-1:0] CH_LBRACK  = 16'h005B;
	localparam logic [CHAR_W-1:0] CH_RBRACK  = 16'h005D;
	localparam logic [CHAR_W-1:0] CH_LBRACE  = 16'h007B;
	localparam logic [CHAR_W-1:0] CH_RBRACE  = 16'h007D;
	localparam logic [CHAR_W-1:0] CH_SPACE   = 16'h0020;
	localparam logic [CHAR_W-1:0] CH_TAB     = 16'h0009;
	localparam logic [CHAR_W-1:0] CH_CR      = 16'h000D;

	// Bit positions in the enclosure flags.
	localparam int FLAG_SQ  = 0;
	localparam int FLAG_DQ  = 1;
	localparam int FLAG_PAR = 2;
	localparam int FLAG_BRK = 3;
	localparam int FLAG_BRC = 4;

	typedef struct packed {
		logic [DELIM_REG_W-1:0] chars;
		logic [LEN_W-1:0]       length;
		logic                   trim;
	} cfg_t;

	typedef struct packed {
		logic [OUT_W-1:0] start;
		logic [OUT_W-1:0] length;
		logic             last;
	} tok_t;

	// Results of one processed character: zero, one or two tokens, in order.
	typedef struct packed {
		logic [PUSH_W-1:0] cnt;
		tok_t              tok_a;
		tok_t              tok_b;
	} push_t;

	// C-locale whitespace.
	function automatic logic is_space(logic [CHAR_W-1:0] c);
		return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

	// Delimiter character k; characters beyond the register read as zero.
	function automatic logic [CHAR_W-1:0] delim_char(logic [DELIM_REG_W-1:0] chars, int k);
		logic [CHAR_W-1:0] r;
		r = '0;
		if (k < DCHARS)
			r = chars[k*CHAR_W +: CHAR_W];
		return r;
	endfunction

	// Length register mapped into 1..MAX_DELIM.
	function automatic logic [FILL_W-1:0] clamp_len(logic [LEN_W-1:0] v);
		logic [FILL_W-1:0] r;
		if (v == '0)
			r = FILL_W'(1);
		else if (int'(v) > MAX_DELIM)
			r = FILL_W'(MAX_DELIM);
		else
			r = FILL_W'(v);
		return r;
	endfunction

	// Position advance that sticks at the top value.
	function automatic logic [POS_BITS-1:0] sat_add(logic [POS_BITS-1:0] p,
		logic [FILL_W-1:0] n);
		logic [POSX_W-1:0] s;
		s = POSX_W'(p) + POSX_W'(n);
		return (s > POSX_W'(POS_MAX)) ? POS_MAX : s[POS_BITS-1:0];
	endfunction

	// Token bounds from the running state, trimmed or not.
	function automatic tok_t make_tok(logic trim, logic seen, logic [POS_BITS-1:0] fns,
		logic [POS_BITS-1:0] lns, logic [POS_BITS-1:0] tbeg, logic [POS_BITS-1:0] pos,
		logic last);
		logic [POS_BITS:0]   span;
		logic [POS_BITS-1:0] st;
		logic [POS_BITS-1:0] ln;
		tok_t                t;
		span = {1'b0, lns} - {1'b0, fns} + (POS_BITS+1)'(1);
		if (trim) begin
			if (seen) begin
				st = fns;
				ln = span[POS_BITS] ? POS_MAX : span[POS_BITS-1:0];
			end else begin
				st = tbeg;
				ln = '0;
			end
		end else begin
			st = tbeg;
			ln = (pos > tbeg) ? (pos - tbeg) : '0;
		end
		t.start  = OUT_W'(st);
		t.length = OUT_W'(ln);
		t.last   = last;
		return t;
	endfunction

endpackage

/* hw/rtl/qads_core.sv */
module qads_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          go,
	input  logic [qads_pkg::CHAR_W-1:0]   char_code,
	input  logic                          eos,
	input  qads_pkg::cfg_t                cfg,
	output qads_pkg::push_t               push
);

	// String state.
	logic [qads_pkg::CHAR_W-1:0]   win_q [qads_pkg::MAX_DELIM];
	logic [qads_pkg::FILL_W-1:0]   fill_q;
	logic [qads_pkg::FILL_W-1:0]   len_q;
	logic [qads_pkg::FLAG_W-1:0]   flags_q;
	logic [qads_pkg::POS_BITS-1:0] pos_q;
	logic [qads_pkg::POS_BITS-1:0] tbeg_q;
	logic [qads_pkg::POS_BITS-1:0] fns_q;
	logic [qads_pkg::POS_BITS-1:0] lns_q;
	logic                          seen_q;

	// Next-state and decision signals.
	logic [qads_pkg::CHAR_W-1:0]   wp [qads_pkg::MAX_DELIM];
	logic [qads_pkg::CHAR_W-1:0]   win_n [qads_pkg::MAX_DELIM];
	logic [qads_pkg::FILL_W-1:0]   act_len;
	logic [qads_pkg::FILL_W-1:0]   fillp;
	logic [qads_pkg::FILL_W-1:0]   fill_n;
	logic [qads_pkg::FILL_W-1:0]   n_dec;
	logic [qads_pkg::FILL_W-1:0]   pos_adv;
	logic [qads_pkg::FLAG_W-1:0]   flag_upd;
	logic [qads_pkg::FLAG_W-1:0]   flags_n;
	logic [qads_pkg::CHAR_W-1:0]   c0;
	logic                          enough;
	logic                          is_fc;
	logic                          all_eq;
	logic                          match;
	logic [qads_pkg::POS_BITS-1:0] pos_n;
	logic [qads_pkg::POS_BITS-1:0] pos_i;
	logic [qads_pkg::POS_BITS-1:0] tbeg_w;
	logic [qads_pkg::POS_BITS-1:0] fns_w;
	logic [qads_pkg::POS_BITS-1:0] lns_w;
	logic                          seen_w;
	qads_pkg::tok_t                tok_d;
	qads_pkg::tok_t                tok_f;

	// Window with the new character appended and the delimiter length for this string.
	always_comb begin
		act_len = ((pos_q == '0) && (fill_q == '0)) ? qads_pkg::clamp_len(cfg.length) : len_q;
		fillp   = fill_q + qads_pkg::FILL_W'(1);
		enough  = (fillp >= act_len);
		for (int i = 0; i < qads_pkg::MAX_DELIM; i++)
			wp[i] = (qads_pkg::FILL_W'(i) < fill_q) ? win_q[i] : char_code;
		c0 = wp[0];
	end

	// Enclosure characters at the front of the window.
	always_comb begin
		flag_upd = flags_q;
		is_fc    = 1'b1;
		unique case (c0)
			qads_pkg::CH_SQUOTE: flag_upd[qads_pkg::FLAG_SQ]  = ~flags_q[qads_pkg::FLAG_SQ];
			qads_pkg::CH_DQUOTE: flag_upd[qads_pkg::FLAG_DQ]  = ~flags_q[qads_pkg::FLAG_DQ];
			qads_pkg::CH_LPAREN: flag_upd[qads_pkg::FLAG_PAR] = 1'b1;
			qads_pkg::CH_RPAREN: flag_upd[qads_pkg::FLAG_PAR] = 1'b0;
			qads_pkg::CH_LBRACK: flag_upd[qads_pkg::FLAG_BRK] = 1'b1;
			qads_pkg::CH_RBRACK: flag_upd[qads_pkg::FLAG_BRK] = 1'b0;
			qads_pkg::CH_LBRACE: flag_upd[qads_pkg::FLAG_BRC] = 1'b1;
			qads_pkg::CH_RBRACE: flag_upd[qads_pkg::FLAG_BRC] = 1'b0;
			default:             is_fc = 1'b0;
		endcase
	end

	// Parallel delimiter compare over the window.
	always_comb begin
		all_eq = 1'b1;
		for (int k = 0; k < qads_pkg::MAX_DELIM; k++) begin
			if ((qads_pkg::FILL_W'(k) < act_len) &&
				(wp[k] != qads_pkg::delim_char(cfg.chars, k)))
				all_eq = 1'b0;
		end
		match = enough && !is_fc && (flags_q == '0) && all_eq;
	end

	// Characters decided without a match: at most one mid-string, all pending ones at the end.
	always_comb begin
		if (match)
			n_dec = '0;
		else if (eos)
			n_dec = fillp;
		else if (enough)
			n_dec = qads_pkg::FILL_W'(1);
		else
			n_dec = '0;
		pos_adv = match ? act_len : n_dec;
		pos_n   = qads_pkg::sat_add(pos_q, pos_adv);
	end

	// Whitespace bounds of the running token, and the token start after a match.
	always_comb begin
		seen_w = match ? 1'b0 : seen_q;
		fns_w  = match ? '0 : fns_q;
		lns_w  = match ? '0 : lns_q;
		tbeg_w = match ? pos_n : tbeg_q;
		pos_i  = pos_q;
		for (int i = 0; i < qads_pkg::MAX_DELIM; i++) begin
			pos_i = qads_pkg::sat_add(pos_q, qads_pkg::FILL_W'(i));
			if ((qads_pkg::FILL_W'(i) < n_dec) && !qads_pkg::is_space(wp[i])) begin
				if (!seen_w) begin
					fns_w  = pos_i;
					seen_w = 1'b1;
				end
				lns_w = pos_i;
			end
		end
	end

	// Window and flags for the next character.
	always_comb begin
		for (int i = 0; i < qads_pkg::MAX_DELIM; i++)
			win_n[i] = wp[i];
		fill_n  = fillp;
		flags_n = flags_q;
		if (match) begin
			fill_n = '0;
		end else if (enough) begin
			for (int i = 0; i < qads_pkg::MAX_DELIM - 1; i++)
				win_n[i] = wp[i+1];
			win_n[qads_pkg::MAX_DELIM-1] = '0;
			fill_n  = fillp - qads_pkg::FILL_W'(1);
			flags_n = flag_upd;
		end
	end

	// Tokens: one closed by a delimiter, one closed by the end of the string.
	always_comb begin
		tok_d = qads_pkg::make_tok(cfg.trim, seen_q, fns_q, lns_q, tbeg_q, pos_q, 1'b0);
		tok_f = qads_pkg::make_tok(cfg.trim, seen_w, fns_w, lns_w, tbeg_w, pos_n, 1'b1);
		push.cnt   = '0;
		push.tok_a = match ? tok_d : tok_f;
		push.tok_b = tok_f;
		if (go)
			push.cnt = qads_pkg::PUSH_W'(match) + qads_pkg::PUSH_W'(eos);
	end

	// State registers; the end of a string clears everything but the latched length.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < qads_pkg::MAX_DELIM; i++)
				win_q[i] <= '0;
			fill_q  <= '0;
			len_q   <= qads_pkg::FILL_W'(1);
			flags_q <= '0;
			pos_q   <= '0;
			tbeg_q  <= '0;
			fns_q   <= '0;
			lns_q   <= '0;
			seen_q  <= 1'b0;
		end else if (go) begin
			len_q <= act_len;
			if (eos) begin
				for (int i = 0; i < qads_pkg::MAX_DELIM; i++)
					win_q[i] <= '0;
				fill_q  <= '0;
				flags_q <= '0;
				pos_q   <= '0;
				tbeg_q  <= '0;
				fns_q   <= '0;
				lns_q   <= '0;
				seen_q  <= 1'b0;
			end else begin
				for (int i = 0; i < qads_pkg::MAX_DELIM; i++)
					win_q[i] <= win_n[i];
				fill_q  <= fill_n;
				flags_q <= flags_n;
				pos_q   <= pos_n;
				tbeg_q  <= tbeg_w;
				fns_q   <= fns_w;
				lns_q   <= lns_w;
				seen_q  <= seen_w;
			end
		end
	end

endmodule

/* hw/rtl/qads_fifo.sv */
module qads_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  qads_pkg::push_t push,
	input  logic            pop,
	output qads_pkg::tok_t  head,
	output logic            avail,
	output logic            room
);

	qads_pkg::tok_t                  mem_q [qads_pkg::FIFO_DEPTH];
	logic [qads_pkg::FIFO_PTR_W-1:0] wptr_q;
	logic [qads_pkg::FIFO_PTR_W-1:0] rptr_q;
	logic [qads_pkg::FIFO_CNT_W-1:0] cnt_q;
	logic [qads_pkg::FIFO_PTR_W-1:0] wptr_b;
	logic                            do_pop;

	// Status: room means a two-token beat always fits.
	assign avail  = (cnt_q != '0);
	assign room   = (cnt_q <= qads_pkg::FIFO_CNT_W'(qads_pkg::FIFO_DEPTH - 2));
	assign head   = mem_q[rptr_q];
	assign do_pop = pop && avail;
	assign wptr_b = wptr_q + qads_pkg::FIFO_PTR_W'(1);

	// Token storage, up to two writes per cycle.
	always_ff @(posedge clk) begin
		if (push.cnt != '0)
			mem_q[wptr_q] <= push.tok_a;
		if (push.cnt == qads_pkg::PUSH_W'(2))
			mem_q[wptr_b] <= push.tok_b;
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			wptr_q <= wptr_q + qads_pkg::FIFO_PTR_W'(push.cnt);
			rptr_q <= rptr_q + qads_pkg::FIFO_PTR_W'(do_pop);
			cnt_q  <= cnt_q + qads_pkg::FIFO_CNT_W'(push.cnt) - qads_pkg::FIFO_CNT_W'(do_pop);
		end
	end

endmodule

/* hw/rtl/quote_aware_delimiter_splitter_unit.sv */
// A beat passes the input register; the core writes its tokens into the token queue.
// Throughput: one character beat per cycle; tokens leave one per cycle, while m_axis_tready
// is high, through a four-entry token queue, and a string end that also closes a delimiter
// yields two. The input side stalls only when that queue holds more than two tokens.
// Reset (arst_n low) clears all string state and the queue, and sets the delimiter to a
// single comma, length one, with trimming off.
`include "assert_macros.svh"

module quote_aware_delimiter_splitter_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	input  logic [qads_pkg::CHAR_W-1:0]           s_axis_tdata,  // char_code
	input  logic                                  s_axis_tlast,  // end_of_string
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	output logic [2*qads_pkg::OUT_W-1:0]          m_axis_tdata,  // token_start, token_length
	output logic                                  m_axis_tlast,  // last_token
	input  logic                                  cfg_we,
	input  logic [qads_pkg::REG_IDX_W-1:0]        cfg_index,
	input  logic [qads_pkg::DELIM_REG_W-1:0]      cfg_data
);

	qads_pkg::cfg_t              cfg_q;
	logic [qads_pkg::CHAR_W-1:0] char_s1;
	logic                        eos_s1;
	logic                        v_s1;
	logic                        fifo_room;
	logic                        adv;
	logic                        s_accept;
	qads_pkg::push_t             push;
	qads_pkg::tok_t              head;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.chars  <= qads_pkg::RST_DELIM_CHARS;
			cfg_q.length <= qads_pkg::RST_DELIM_LENGTH;
			cfg_q.trim   <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				qads_pkg::REG_DELIM_CHARS:  cfg_q.chars  <= cfg_data;
				qads_pkg::REG_DELIM_LENGTH: cfg_q.length <= cfg_data[qads_pkg::LEN_W-1:0];
				qads_pkg::REG_TRIM_ENABLE:  cfg_q.trim   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Input register: a character is processed once the token queue has room for two.
	assign adv           = v_s1 && fifo_room;
	assign s_axis_tready = !v_s1 || fifo_room;
	assign s_accept      = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else
			v_s1 <= s_accept || (v_s1 && !adv);
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			char_s1 <= s_axis_tdata;
			eos_s1  <= s_axis_tlast;
		end
	end

	// Splitting logic and token queue.
	qads_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (adv),
		.char_code (char_s1),
		.eos       (eos_s1),
		.cfg       (cfg_q),
		.push      (push)
	);

	qads_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (m_axis_tready),
		.head   (head),
		.avail  (m_axis_tvalid),
		.room   (fifo_room)
	);

	assign m_axis_tdata = {head.length, head.start};
	assign m_axis_tlast = head.last;

	// Checks on the split between input register, core and queue.
	`QADS_ASSERT_IMP(a_push_room, clk, arst_n, push.cnt != 2'd0, fifo_room)
	`QADS_ASSERT_IMP(a_eos_token, clk, arst_n, adv && eos_s1, push.cnt != 2'd0)
	`QADS_ASSERT_IMP(a_mid_single, clk, arst_n, adv && !eos_s1, push.cnt != 2'd2)
	`QADS_ASSERT_NXT(a_s1_hold, clk, arst_n, v_s1 && !adv, v_s1)

endmodule
